// ----- hw/rtl/kmd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the key matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROWS          = 4;
    localparam int COLS          = 14;
    localparam int ROW_W         = 2;              // width of the row index field
    localparam int ROW_IDX_W     = $clog2(ROWS);   // bits that address a row store
    localparam int OP_W          = 2;
    localparam int MS_W          = 8;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [MS_W-1:0] ELAPSED_MAX    = '1;
    localparam logic [MS_W-1:0] DEBOUNCE_RESET = MS_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef logic [COLS-1:0] row_keys_t;

    // One unit of work for the back end: a read answer or a commit burst.
    typedef struct packed {
        logic                           is_commit;
        logic [ROW_W-1:0]               row;
        logic [ROWS-1:0][COLS-1:0]      keys;   // read answer uses slot 0
    } work_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/key_matrix_debouncer_core.sv -----
`default_nettype none
// With the back end idle, a read or commit passes the work queue and the back end's work
// register before its first row is on m_*. One input item per cycle while the queue is not
// full; ticks and non-committing samples cost nothing at the output, a read one transfer,
// a commit one per row. The result port, fed by a two-entry work queue, sets the rate.
// Reset (aresetn low, synchronous): stable and pending rows, change flag and elapsed
// count cleared, debounce time set to 5 ms, queue emptied.
// ----------------------------------------------------------------------------
// key_matrix_debouncer_core
// Key matrix debouncer with one global timer, split into front, queue and back.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kmd_pkg::OP_W-1:0]      s_op,
    input  wire logic [kmd_pkg::ROW_W-1:0]     s_row_index,
    input  wire logic [kmd_pkg::COLS-1:0]      s_column_levels,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kmd_pkg::ROW_W-1:0]          m_out_row,
    output logic [kmd_pkg::COLS-1:0]           m_row_keys,
    output logic                               m_is_commit,
    output logic                               m_last_row,
    input  wire logic                          cfg_wr_en,
    input  wire logic [kmd_pkg::MS_W-1:0]      cfg_wr_data
);

    logic                    push, pop;
    kmd_pkg::work_t          push_data, pop_data;
    kmd_pkg::queue_status_t  q_status;

    assign s_ready = !q_status.full;

    kmd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_valid && s_ready),
        .op            (s_op),
        .row_index     (s_row_index),
        .column_levels (s_column_levels),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push),
        .push_data     (push_data)
    );

    kmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    kmd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (!q_status.empty),
        .q_data      (pop_data),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_row_keys  (m_row_keys),
        .m_is_commit (m_is_commit),
        .m_last_row  (m_last_row)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(q_status.count) <= kmd_pkg::QDEPTH)
        else $error("work queue count exceeds depth");

    a_read_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_commit |-> m_last_row)
        else $error("read answer not marked last");

    a_commit_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_is_commit && !m_last_row |=>
            m_valid && m_is_commit && (m_out_row == $past(m_out_row) + 2'd1))
        else $error("commit burst rows out of order");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/kmd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_front
// Accepts items, keeps the debounce state and queues read/commit work.
// ----------------------------------------------------------------------------
module kmd_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic [kmd_pkg::OP_W-1:0]     op,
    input  wire logic [kmd_pkg::ROW_W-1:0]    row_index,
    input  wire logic [kmd_pkg::COLS-1:0]     column_levels,
    input  wire logic                         cfg_wr_en,
    input  wire logic [kmd_pkg::MS_W-1:0]     cfg_wr_data,
    output logic                              push,
    output kmd_pkg::work_t                    push_data
);

    localparam logic [kmd_pkg::MS_W-1:0] MS_W_ONE = kmd_pkg::MS_W'(1);

    kmd_pkg::row_keys_t            stable_reg  [kmd_pkg::ROWS];
    kmd_pkg::row_keys_t            stable_next [kmd_pkg::ROWS];
    kmd_pkg::row_keys_t            pending_reg [kmd_pkg::ROWS];
    kmd_pkg::row_keys_t            pending_next[kmd_pkg::ROWS];
    logic                          change_reg, change_next;
    logic [kmd_pkg::MS_W-1:0]      elapsed_reg, elapsed_next;
    logic [kmd_pkg::MS_W-1:0]      debounce_reg;

    logic                          row_ok;
    logic [kmd_pkg::ROW_IDX_W-1:0] ridx;
    kmd_pkg::row_keys_t            keys;
    logic                          changed;

    assign ridx   = row_index[kmd_pkg::ROW_IDX_W-1:0];
    assign row_ok = 32'(row_index) < 32'(kmd_pkg::ROWS);
    assign keys   = ~column_levels;

    always_comb begin
        stable_next  = stable_reg;
        pending_next = pending_reg;
        change_next  = change_reg;
        elapsed_next = elapsed_reg;
        push         = 1'b0;
        push_data    = '0;
        changed      = pending_reg[ridx] != keys;
        push_data.row = row_index;

        if (accept) begin
            case (kmd_pkg::op_t'(op))
                kmd_pkg::OP_TICK: begin
                    if (elapsed_reg != kmd_pkg::ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + MS_W_ONE;
                    end
                end
                kmd_pkg::OP_READ: begin
                    push = 1'b1;
                    push_data.keys[0] = row_ok ? stable_reg[ridx] : '0;
                end
                kmd_pkg::OP_SAMPLE: begin
                    if (row_ok) begin
                        if (changed) begin
                            pending_next[ridx] = keys;
                            change_next        = 1'b1;
                            elapsed_next       = '0;
                        end
                        if (32'(row_index) == 32'(kmd_pkg::ROWS - 1) && change_next
                            && elapsed_next >= debounce_reg) begin
                            stable_next         = pending_next;
                            change_next         = 1'b0;
                            push                = 1'b1;
                            push_data.is_commit = 1'b1;
                            for (int r = 0; r < kmd_pkg::ROWS; r++) begin
                                push_data.keys[r] = pending_next[r];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < kmd_pkg::ROWS; r++) begin
                stable_reg[r]  <= '0;
                pending_reg[r] <= '0;
            end
            change_reg   <= 1'b0;
            elapsed_reg  <= '0;
            debounce_reg <= kmd_pkg::DEBOUNCE_RESET;
        end else begin
            stable_reg  <= stable_next;
            pending_reg <= pending_next;
            change_reg  <= change_next;
            elapsed_reg <= elapsed_next;
            if (cfg_wr_en) begin
                debounce_reg <= cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/kmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_queue
// Two-entry work queue between the front and back ends.
// ----------------------------------------------------------------------------
module kmd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire kmd_pkg::work_t     push_data,
    input  wire logic               pop,
    output kmd_pkg::work_t          pop_data,
    output kmd_pkg::queue_status_t  status
);

    kmd_pkg::work_t                mem_reg [kmd_pkg::QDEPTH];
    logic [kmd_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [kmd_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign status.count = count_reg;
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == kmd_pkg::QCNT_W'(kmd_pkg::QDEPTH);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + kmd_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - kmd_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == kmd_pkg::QDEPTH - 1)
                              ? '0 : wr_ptr_reg + kmd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == kmd_pkg::QDEPTH - 1)
                              ? '0 : rd_ptr_reg + kmd_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/kmd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_back
// Drains queued work onto the result channel, one row per transfer.
// ----------------------------------------------------------------------------
module kmd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire kmd_pkg::work_t                q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kmd_pkg::ROW_W-1:0]          m_out_row,
    output logic [kmd_pkg::COLS-1:0]           m_row_keys,
    output logic                               m_is_commit,
    output logic                               m_last_row
);

    logic                              busy_reg;
    kmd_pkg::work_t                    work_reg;
    logic [kmd_pkg::ROW_IDX_W-1:0]     idx_reg;
    logic                              last;

    assign last    = !work_reg.is_commit || 32'(idx_reg) == kmd_pkg::ROWS - 1;
    assign q_pop   = q_valid && (!busy_reg || (m_ready && last));

    assign m_valid     = busy_reg;
    assign m_is_commit = work_reg.is_commit;
    assign m_last_row  = last;
    assign m_out_row   = work_reg.is_commit ? kmd_pkg::ROW_W'(idx_reg) : work_reg.row;
    assign m_row_keys  = work_reg.is_commit ? work_reg.keys[idx_reg] : work_reg.keys[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + kmd_pkg::ROW_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_data;
        end
    end

endmodule
`default_nettype wire

// ----- sim/key_matrix_debouncer_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_debouncer_checker
// Watches the sample and result channels of the debouncer, keeps its own copy
// of the pending and stable key matrix, and compares every result transfer
// field by field against the oldest predicted row.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_checker
    import kmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [OP_W-1:0]      s_op,
    input  wire logic [ROW_W-1:0]     s_row_index,
    input  wire logic [COLS-1:0]      s_column_levels,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [ROW_W-1:0]     m_out_row,
    input  wire logic [COLS-1:0]      m_row_keys,
    input  wire logic                 m_is_commit,
    input  wire logic                 m_last_row,
    input  wire logic                 cfg_wr_en,
    input  wire logic [MS_W-1:0]      cfg_wr_data,
    output int                        fail_count,
    output int                        rows_outstanding,
    output int                        items_seen,
    output int                        results_seen,
    output int                        commit_bursts,
    output int                        reads_seen
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COLS-1:0]  keys;
        logic             commit;
        logic             last;
    } key_row_t;

    row_keys_t       stable_keys  [ROWS];
    row_keys_t       scanned_keys [ROWS];
    logic            change_seen;
    logic [MS_W-1:0] quiet_ms;
    logic [MS_W-1:0] settle_ms;
    key_row_t        expected_rows [$];

    int errors;
    int item_total;
    int result_total;
    int commit_total;
    int read_total;

    assign fail_count    = errors;
    assign items_seen    = item_total;
    assign results_seen  = result_total;
    assign commit_bursts = commit_total;
    assign reads_seen    = read_total;

    initial begin
        errors       = 0;
        item_total   = 0;
        result_total = 0;
        commit_total = 0;
        read_total   = 0;
        rows_outstanding = 0;
    end

    task automatic clear_matrix();
        for (int r = 0; r < ROWS; r++) begin
            stable_keys[r]  = '0;
            scanned_keys[r] = '0;
        end
        change_seen = 1'b0;
        quiet_ms    = '0;
        settle_ms   = DEBOUNCE_RESET;
        expected_rows.delete();
    endtask

    // Advances the matrix by one accepted item and queues the rows it produces.
    task automatic debounce_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                                 input logic [COLS-1:0] levels);
        row_keys_t pressed;
        key_row_t  res;
        pressed = ~levels;
        case (op)
            OP_TICK: begin
                if (quiet_ms != ELAPSED_MAX)
                    quiet_ms = quiet_ms + 1'b1;
            end
            OP_READ: begin
                res.row    = row;
                res.keys   = (int'(row) < ROWS) ? stable_keys[row] : '0;
                res.commit = 1'b0;
                res.last   = 1'b1;
                expected_rows.push_back(res);
                read_total++;
            end
            OP_SAMPLE: begin
                if (int'(row) < ROWS) begin
                    if (scanned_keys[row] != pressed) begin
                        scanned_keys[row] = pressed;
                        change_seen       = 1'b1;
                        quiet_ms          = '0;
                    end
                    if (int'(row) == ROWS - 1 && change_seen && quiet_ms >= settle_ms) begin
                        change_seen = 1'b0;
                        for (int r = 0; r < ROWS; r++) begin
                            stable_keys[r] = scanned_keys[r];
                            res.row    = ROW_W'(r);
                            res.keys   = stable_keys[r];
                            res.commit = 1'b1;
                            res.last   = (r == ROWS - 1);
                            expected_rows.push_back(res);
                        end
                        commit_total++;
                    end
                end
            end
            default: ;  // unused op code is dropped
        endcase
    endtask

    task automatic compare_field(input string name, input logic [COLS-1:0] want,
                                 input logic [COLS-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        key_row_t want;
        if (!aresetn) begin
            clear_matrix();
        end else begin
            // results first: nothing accepted on this edge can already be on m_*
            if (m_valid && m_ready) begin
                result_total++;
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual row %0d keys %0h",
                             $time, m_out_row, m_row_keys);
                end else begin
                    want = expected_rows.pop_front();
                    compare_field("out_row",   COLS'(want.row),    COLS'(m_out_row));
                    compare_field("row_keys",  want.keys,          m_row_keys);
                    compare_field("is_commit", COLS'(want.commit), COLS'(m_is_commit));
                    compare_field("last_row",  COLS'(want.last),   COLS'(m_last_row));
                end
            end
            if (s_valid && s_ready) begin
                item_total++;
                debounce_item(s_op, s_row_index, s_column_levels);
            end
            if (cfg_wr_en)
                settle_ms = cfg_wr_data;
        end
        rows_outstanding <= expected_rows.size();
    end

endmodule
`default_nettype wire

// ----- sim/key_matrix_debouncer_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_debouncer_core_tb
// Drives row samples, millisecond ticks and reads into the debouncer under
// random sender gaps and receiver stalls, across several debounce times, and
// leaves the checking to key_matrix_debouncer_checker.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_core_tb;
    import kmd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 8;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_op;
    logic [ROW_W-1:0]  s_row_index;
    logic [COLS-1:0]   s_column_levels;
    logic              m_valid;
    logic              m_ready;
    logic [ROW_W-1:0]  m_out_row;
    logic [COLS-1:0]   m_row_keys;
    logic              m_is_commit;
    logic              m_last_row;
    logic              cfg_wr_en;
    logic [MS_W-1:0]   cfg_wr_data;

    int fail_count;
    int rows_outstanding;
    int items_seen;
    int results_seen;
    int commit_bursts;
    int reads_seen;

    int          sent_items;
    bit          tx_dense;
    int          hold_req;
    int          hold_done;
    int unsigned cycle_count;
    logic [COLS-1:0] driven_levels [ROWS];

    key_matrix_debouncer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_row_index     (s_row_index),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_row_keys      (m_row_keys),
        .m_is_commit     (m_is_commit),
        .m_last_row      (m_last_row),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    key_matrix_debouncer_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_row_index      (s_row_index),
        .s_column_levels  (s_column_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_row_keys       (m_row_keys),
        .m_is_commit      (m_is_commit),
        .m_last_row       (m_last_row),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .fail_count       (fail_count),
        .rows_outstanding (rows_outstanding),
        .items_seen       (items_seen),
        .results_seen     (results_seen),
        .commit_bursts    (commit_bursts),
        .reads_seen       (reads_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stall per transfer, quiet stretches, one long hold-off.
    initial begin : result_sink
        int  stall;
        int  xfers;
        bit  rx_dense;
        bit  seen_valid;
        stall      = 0;
        xfers      = 0;
        rx_dense   = 1'b0;
        seen_valid = 1'b0;
        hold_done  = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            seen_valid = m_valid;
            if (aresetn && m_valid && m_ready) begin
                xfers++;
                if (xfers % 40 == 0)
                    rx_dense = ($urandom_range(0, 2) == 0);
                stall = rx_dense ? 0 : $urandom_range(0, 15);
            end
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done++;
            end
            m_ready <= (stall == 0);
            if (stall > 0 && seen_valid)
                stall--;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                             input logic [COLS-1:0] levels);
        int gap;
        gap = tx_dense ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_row_index     <= row;
        s_column_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic sample_row(input int r, input logic [COLS-1:0] levels);
        driven_levels[r] = levels;
        send_item(OP_SAMPLE, ROW_W'(r), levels);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, ROW_W'($urandom), COLS'($urandom));
    endtask

    task automatic read_row(input int r);
        send_item(OP_READ, ROW_W'(r), COLS'($urandom));
    endtask

    // Drop valid, then wait for every predicted row plus the pipeline tail.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (rows_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_debounce(input logic [MS_W-1:0] ms);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ms;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [COLS-1:0] bounce(input logic [COLS-1:0] levels);
        if ($urandom_range(0, 2) == 0)
            return COLS'($urandom);
        return levels ^ (COLS'(1) << $urandom_range(0, COLS - 1));
    endfunction

    // Mostly full row scans with occasional key changes, ticks between scans,
    // reads, and some noise: stray samples, partial scans, unused op code.
    task automatic run_phase(input int n_items);
        int start;
        int pick;
        int changed;
        int stop_at;
        start = sent_items;
        while (sent_items - start < n_items) begin
            if ($urandom_range(0, 19) == 0)
                tx_dense = ~tx_dense;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                changed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1) : -1;
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROWS - 1) : ROWS - 1;
                for (int r = 0; r <= stop_at; r++)
                    sample_row(r, (r == changed) ? bounce(driven_levels[r]) : driven_levels[r]);
            end else if (pick < 80) begin
                send_ticks($urandom_range(1, 4));
            end else if (pick < 92) begin
                read_row($urandom_range(0, ROWS - 1));
            end else if (pick < 96) begin
                send_item(OP_UNUSED, ROW_W'($urandom), COLS'($urandom));
            end else begin
                sample_row($urandom_range(0, ROWS - 1), COLS'($urandom));
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_op            = OP_SAMPLE;
        s_row_index     = '0;
        s_column_levels = '1;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        sent_items      = 0;
        tx_dense        = 1'b0;
        hold_req        = 0;
        for (int r = 0; r < ROWS; r++)
            driven_levels[r] = '1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty matrix, ignored op, all-pressed row, commit at the limit.
        for (int r = 0; r < ROWS; r++)
            read_row(r);
        send_item(OP_UNUSED, ROW_W'($urandom), COLS'($urandom));
        sample_row(0, '0);
        sample_row(1, '1);
        sample_row(2, '1);
        sample_row(3, '1);
        send_ticks(4);
        sample_row(3, '1);          // one ms short of the reset debounce time
        send_ticks(1);
        sample_row(3, '1);          // commits now
        read_row(0);

        // Zero debounce: a change in the last row commits on the spot.
        set_debounce('0);
        sample_row(3, 14'h2AAA);
        sample_row(3, 14'h2AAA);    // no change, nothing pending
        sample_row(1, 14'h1555);
        read_row(1);
        sample_row(3, 14'h2AAA);
        read_row(1);

        // Longest debounce: one ms short, then past the top of the count, which
        // only commits if the count holds at its maximum instead of wrapping.
        set_debounce(ELAPSED_MAX);
        tx_dense = 1'b1;
        sample_row(2, driven_levels[2] ^ COLS'(1));
        send_ticks(254);
        sample_row(3, driven_levels[3]);
        send_ticks(3);
        sample_row(3, driven_levels[3]);
        tx_dense = 1'b0;

        set_debounce(2);
        run_phase(PHASE_ITEMS);

        // Block the result port while reads keep coming, so the input backs up.
        set_debounce(1);
        hold_req++;
        tx_dense = 1'b1;
        for (int i = 0; i < 12; i++)
            read_row(i % ROWS);
        tx_dense = 1'b0;
        run_phase(PHASE_ITEMS);

        set_debounce('0);
        run_phase(PHASE_ITEMS);
        set_debounce(MS_W'($urandom_range(0, 6)));
        run_phase(PHASE_ITEMS);
        set_debounce(3);
        run_phase(PHASE_ITEMS);

        drain();
        $display("Covered %0d input transfers and %0d result transfers:",
                 items_seen, results_seen);
        $display("%0d commit bursts, %0d reads; debounce times 0 to 255 ms, %s",
                 commit_bursts, reads_seen, "tick count saturation, input back-pressure.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_front.sv
hw/rtl/kmd_queue.sv
hw/rtl/kmd_back.sv
hw/rtl/key_matrix_debouncer_core.sv
sim/key_matrix_debouncer_checker.sv
sim/key_matrix_debouncer_core_tb.sv
